// ===== rtl/core/lfs_pkg.sv =====
// ============================================================================
// lfs_pkg: shared types and constants of the line follow steering core
// Drive modes, register indexes, pipeline payloads and the angle tables.
// ============================================================================
`default_nettype none

package lfs_pkg;

    localparam int GAIN_DEN      = 8;
    localparam int FORWARD_ANGLE = 45;
    localparam int POWER_MAX     = 100;

    localparam int ANGLE_STEPS = 90;
    localparam int ANGLE_W     = $clog2(ANGLE_STEPS + 1);
    localparam int FRAC_BITS   = 40;
    localparam int ROM_W       = FRAC_BITS + 1;
    localparam int PROD_W      = ROM_W + 8;

    // Angle step k is k*157/ROM_DEN rad.
    localparam longint ROM_DEN      = 9000;
    localparam int     SERIES_TERMS = 16;

    // Term ratios of the sine series, (2n)(2n+1), and of the cosine series, (2n-1)(2n).
    localparam longint SIN_DIV [1:SERIES_TERMS] = '{
        6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600, 702, 812, 930, 1056
    };
    localparam longint COS_DIV [1:SERIES_TERMS] = '{
        2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552, 650, 756, 870, 992
    };

    // Division by 100 as a multiplication by a rounded-up reciprocal.
    localparam int MIX_RECIP = 5243;
    localparam int MIX_SHIFT = 19;
    localparam int MIX_W     = 14 + 13;

    localparam logic [ANGLE_W-1:0] PROBE_INIT = ANGLE_W'(1) << (ANGLE_W - 1);

    localparam logic [7:0] WHITE_LEFT_RST  = 8'd0;
    localparam logic [7:0] WHITE_RIGHT_RST = 8'd0;
    localparam logic [7:0] BLACK_LEFT_RST  = 8'd255;
    localparam logic [7:0] BLACK_RIGHT_RST = 8'd255;
    localparam logic [7:0] BLACK_LIM_RST   = 8'd20;
    localparam logic [7:0] WHITE_LIM_RST   = 8'd200;
    localparam logic [7:0] GAIN_NUM_RST    = 8'd1;
    localparam logic [6:0] FWD_SPEED_RST   = 7'd50;

    typedef enum logic [1:0] {
        MODE_STEER = 2'd0,
        MODE_BLACK = 2'd1,
        MODE_WHITE = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        REG_WHITE_LEFT  = 3'd0,
        REG_WHITE_RIGHT = 3'd1,
        REG_BLACK_LEFT  = 3'd2,
        REG_BLACK_RIGHT = 3'd3,
        REG_BLACK_LIM   = 3'd4,
        REG_WHITE_LIM   = 3'd5,
        REG_GAIN_NUM    = 3'd6,
        REG_FWD_SPEED   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] white_left;
        logic [7:0] white_right;
        logic [7:0] black_left;
        logic [7:0] black_right;
        logic [7:0] both_black_limit;
        logic [7:0] both_white_limit;
        logic [7:0] gain_num;
        logic [6:0] forward_speed;
    } cfg_t;

    typedef struct packed {
        logic [7:0]         dl;
        logic [7:0]         dr;
        logic [ANGLE_W-1:0] acc;
        logic [ANGLE_W-1:0] probe;
        mode_t              mode;
    } sar_t;

    typedef struct packed {
        mode_t      mode;
        logic [6:0] right;
        logic [6:0] left;
    } res_t;

    typedef logic [ROM_W-1:0] rom_t [0:ANGLE_STEPS];

    // Taylor series of sine and cosine in Q40, evaluated at elaboration.
    function automatic rom_t build_rom(input logic want_cos);
        rom_t   t;
        longint one;
        longint num;
        longint st;
        longint ss;
        longint ct;
        longint cs;
        one = longint'(1) << FRAC_BITS;
        for (int k = 0; k <= ANGLE_STEPS; k++) begin
            num = longint'(k) * 157;
            st  = one * num / ROM_DEN;
            ss  = st;
            ct  = one;
            cs  = one;
            for (int n = 1; n <= SERIES_TERMS; n++) begin
                st = st * num / ROM_DEN;
                st = st * num / ROM_DEN;
                st = st / SIN_DIV[n];
                ct = ct * num / ROM_DEN;
                ct = ct * num / ROM_DEN;
                ct = ct / COS_DIV[n];
                if ((n & 1) == 1) begin
                    ss = ss - st;
                    cs = cs - ct;
                end else begin
                    ss = ss + st;
                    cs = cs + ct;
                end
            end
            t[k] = want_cos ? cs[ROM_W-1:0] : ss[ROM_W-1:0];
        end
        return t;
    endfunction

    localparam rom_t SIN_ROM = build_rom(1'b0);
    localparam rom_t COS_ROM = build_rom(1'b1);

endpackage

`default_nettype wire

// ===== rtl/core/lfs_front.sv =====
// ============================================================================
// lfs_front: sensor clamp and drive mode decision
// Clamps the samples to white, measures the squared distance from black and
// prepares the angle search payload. Two pipeline stages.
// ============================================================================
`default_nettype none

module lfs_front
    import lfs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       in_valid,
    input  wire logic [7:0] in_left,
    input  wire logic [7:0] in_right,
    output logic            in_ready,
    output logic            out_valid,
    output sar_t            out_data,
    input  wire logic       out_ready
);

    logic       v1_reg;
    logic [7:0] dl1_reg;
    logic [7:0] dr1_reg;
    logic [7:0] el1_reg;
    logic [7:0] er1_reg;
    logic       v2_reg;
    sar_t       d2_reg;

    logic       rdy1;
    logic       rdy2;
    logic [7:0] l_c;
    logic [7:0] r_c;
    logic [7:0] dl1_next;
    logic [7:0] dr1_next;
    logic [7:0] el1_next;
    logic [7:0] er1_next;
    logic [16:0] dist2;
    logic [15:0] bb2;
    logic [15:0] ww2;
    sar_t       d2_next;

    assign rdy2     = ~v2_reg | out_ready;
    assign rdy1     = ~v1_reg | rdy2;
    assign in_ready = rdy1;

    always_comb begin
        l_c      = (in_left < cfg.white_left) ? cfg.white_left : in_left;
        r_c      = (in_right < cfg.white_right) ? cfg.white_right : in_right;
        dl1_next = l_c - cfg.white_left;
        dr1_next = r_c - cfg.white_right;
        el1_next = (cfg.black_left >= l_c) ? cfg.black_left - l_c : l_c - cfg.black_left;
        er1_next = (cfg.black_right >= r_c) ? cfg.black_right - r_c : r_c - cfg.black_right;
    end

    always_comb begin
        dist2 = 17'(16'(el1_reg) * 16'(el1_reg)) + 17'(16'(er1_reg) * 16'(er1_reg));
        bb2   = 16'(cfg.both_black_limit) * 16'(cfg.both_black_limit);
        ww2   = 16'(cfg.both_white_limit) * 16'(cfg.both_white_limit);
        d2_next.dl    = dl1_reg;
        d2_next.dr    = dr1_reg;
        d2_next.acc   = '0;
        d2_next.probe = PROBE_INIT;
        // Both at white must read as zero degrees; a unit right reading does that.
        if (dl1_reg == 8'd0 && dr1_reg == 8'd0) begin
            d2_next.dr = 8'd1;
        end
        if (dist2 < 17'(bb2)) begin
            d2_next.mode = MODE_BLACK;
        end else if (dist2 > 17'(ww2)) begin
            d2_next.mode = MODE_WHITE;
        end else begin
            d2_next.mode = MODE_STEER;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            dl1_reg <= dl1_next;
            dr1_reg <= dr1_next;
            el1_reg <= el1_next;
            er1_reg <= er1_next;
        end
        if (rdy2 && v1_reg) begin
            d2_reg <= d2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = d2_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lfs_angle_cell.sv =====
// ============================================================================
// lfs_angle_cell: one step of the arctangent search
// Tries the next angle bit against the sine and cosine tables and keeps it
// when the reading vector lies at or above that angle.
// ============================================================================
`default_nettype none

module lfs_angle_cell
    import lfs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    input  wire sar_t in_data,
    output logic      in_ready,
    output logic      out_valid,
    output sar_t      out_data,
    input  wire logic out_ready
);

    logic               valid_reg;
    sar_t               data_reg;
    sar_t               data_next;
    logic [ANGLE_W-1:0] trial;
    logic [ANGLE_W-1:0] k;
    logic               in_range;
    logic [PROD_W-1:0]  lhs;
    logic [PROD_W-1:0]  rhs;

    assign in_ready = ~valid_reg | out_ready;

    always_comb begin
        trial     = in_data.acc | in_data.probe;
        in_range  = (trial <= ANGLE_W'(ANGLE_STEPS));
        k         = in_range ? trial : '0;
        lhs       = PROD_W'(in_data.dl) * PROD_W'(COS_ROM[k]);
        rhs       = PROD_W'(in_data.dr) * PROD_W'(SIN_ROM[k]);
        data_next       = in_data;
        data_next.probe = in_data.probe >> 1;
        if (in_range && lhs >= rhs) begin
            data_next.acc = trial;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lfs_mix.sv =====
// ============================================================================
// lfs_mix: proportional steering and differential motor mix
// Scales the angle error by the gain, spreads it over the forward speed and
// clamps both motor powers. Four pipeline stages, the last one the output.
// ============================================================================
`default_nettype none

module lfs_mix
    import lfs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cfg_t cfg,
    input  wire logic in_valid,
    input  wire sar_t in_data,
    output logic      in_ready,
    output logic      out_valid,
    output res_t      out_data,
    input  wire logic out_ready
);

    logic             v1_reg;
    logic             v2_reg;
    logic             v3_reg;
    logic             v4_reg;
    logic             neg1_reg;
    logic [6:0]       mag1_reg;
    mode_t            mode1_reg;
    logic             neg2_reg;
    logic [13:0]      x2_reg;
    mode_t            mode2_reg;
    logic             neg3_reg;
    logic [MIX_W-1:0] y3_reg;
    mode_t            mode3_reg;
    res_t             res4_reg;

    logic             rdy1;
    logic             rdy2;
    logic             rdy3;
    logic             rdy4;
    logic signed [7:0]  err;
    logic signed [16:0] prod;
    logic signed [16:0] quo;
    logic             neg1_next;
    logic [6:0]       mag1_next;
    logic [13:0]      x2_next;
    logic [MIX_W-1:0] y3_next;
    logic [7:0]       d;
    logic [8:0]       plus;
    logic [6:0]       minus;
    logic [6:0]       up_c;
    logic [6:0]       dn_c;
    logic [6:0]       fs_cap;
    res_t             res4_next;

    assign rdy4     = ~v4_reg | out_ready;
    assign rdy3     = ~v3_reg | rdy4;
    assign rdy2     = ~v2_reg | rdy3;
    assign rdy1     = ~v1_reg | rdy2;
    assign in_ready = rdy1;

    always_comb begin
        err  = 8'(FORWARD_ANGLE) - signed'({1'b0, in_data.acc});
        prod = 17'(err) * 17'(signed'({1'b0, cfg.gain_num}));
        quo  = prod / 17'(GAIN_DEN);
        neg1_next = (quo < 17'sd0);
        if (quo > 17'(POWER_MAX) || quo < -17'(POWER_MAX)) begin
            mag1_next = 7'(POWER_MAX);
        end else if (quo < 17'sd0) begin
            mag1_next = 7'(-quo);
        end else begin
            mag1_next = 7'(quo);
        end
    end

    always_comb begin
        x2_next = 14'(mag1_reg) * 14'(cfg.forward_speed);
        y3_next = MIX_W'(x2_reg) * MIX_W'(MIX_RECIP);
    end

    always_comb begin
        d      = 8'(y3_reg >> MIX_SHIFT);
        plus   = 9'(cfg.forward_speed) + 9'(d);
        minus  = (8'(cfg.forward_speed) >= d) ? 7'(8'(cfg.forward_speed) - d) : 7'd0;
        up_c   = (plus > 9'(POWER_MAX)) ? 7'(POWER_MAX) : plus[6:0];
        dn_c   = (minus > 7'(POWER_MAX)) ? 7'(POWER_MAX) : minus;
        fs_cap = (cfg.forward_speed > 7'(POWER_MAX)) ? 7'(POWER_MAX) : cfg.forward_speed;
        res4_next.mode = mode3_reg;
        case (mode3_reg)
            MODE_BLACK: begin
                res4_next.left  = fs_cap;
                res4_next.right = fs_cap;
            end
            MODE_WHITE: begin
                res4_next.left  = 7'd0;
                res4_next.right = fs_cap;
            end
            default: begin
                res4_next.left  = neg3_reg ? dn_c : up_c;
                res4_next.right = neg3_reg ? up_c : dn_c;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            neg1_reg  <= neg1_next;
            mag1_reg  <= mag1_next;
            mode1_reg <= in_data.mode;
        end
        if (rdy2 && v1_reg) begin
            neg2_reg  <= neg1_reg;
            x2_reg    <= x2_next;
            mode2_reg <= mode1_reg;
        end
        if (rdy3 && v2_reg) begin
            neg3_reg  <= neg2_reg;
            y3_reg    <= y3_next;
            mode3_reg <= mode2_reg;
        end
        if (rdy4 && v3_reg) begin
            res4_reg <= res4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = res4_reg;

endmodule

`default_nettype wire

// ===== rtl/core/line_follow_steering_core.sv =====
// ============================================================================
// line_follow_steering_core: two-sensor line follower motor steering
// Turns a pair of reflectance samples into left and right motor powers.
// ============================================================================
//
//   channel   direction  payload (lowest bit up)                  handshake
//   s_        in         left_sensor, right_sensor                tvalid/tready
//   m_        out        left_power, right_power; tuser drive_mode tvalid/tready
//   cfg_      in         register index, write data               cfg_we only
//
// One transaction per cycle is taken and delivered while m_tready is high;
// each one passes through 13 register stages: 2 in the front end, 7 angle
// search cells (one per bit of the angle) and 4 in the motor mix, the last
// being the output register. Each stage stalls only when it is full and the
// next one cannot take its data, so bubbles close up while the output waits.
// Reset empties the pipeline and loads the register defaults.
// ============================================================================
`default_nettype none

module line_follow_steering_core
    import lfs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // left_sensor, right_sensor
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // left_power, right_power, zero fill
    output logic [1:0]       m_tuser,   // drive_mode
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic [ANGLE_W:0] chain_valid;
    logic [ANGLE_W:0] chain_ready;
    sar_t             chain_data [0:ANGLE_W];
    res_t             res;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_WHITE_LEFT:  cfg_next.white_left       = cfg_wdata;
                REG_WHITE_RIGHT: cfg_next.white_right      = cfg_wdata;
                REG_BLACK_LEFT:  cfg_next.black_left       = cfg_wdata;
                REG_BLACK_RIGHT: cfg_next.black_right      = cfg_wdata;
                REG_BLACK_LIM:   cfg_next.both_black_limit = cfg_wdata;
                REG_WHITE_LIM:   cfg_next.both_white_limit = cfg_wdata;
                REG_GAIN_NUM:    cfg_next.gain_num         = cfg_wdata;
                REG_FWD_SPEED:   cfg_next.forward_speed    = cfg_wdata[6:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.white_left       <= WHITE_LEFT_RST;
            cfg_reg.white_right      <= WHITE_RIGHT_RST;
            cfg_reg.black_left       <= BLACK_LEFT_RST;
            cfg_reg.black_right      <= BLACK_RIGHT_RST;
            cfg_reg.both_black_limit <= BLACK_LIM_RST;
            cfg_reg.both_white_limit <= WHITE_LIM_RST;
            cfg_reg.gain_num         <= GAIN_NUM_RST;
            cfg_reg.forward_speed    <= FWD_SPEED_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lfs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_left   (s_tdata[7:0]),
        .in_right  (s_tdata[15:8]),
        .in_ready  (s_tready),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0]),
        .out_ready (chain_ready[0])
    );

    for (genvar i = 0; i < ANGLE_W; i++) begin : g_cell
        lfs_angle_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .in_ready  (chain_ready[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1]),
            .out_ready (chain_ready[i+1])
        );
    end

    lfs_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (chain_valid[ANGLE_W]),
        .in_data   (chain_data[ANGLE_W]),
        .in_ready  (chain_ready[ANGLE_W]),
        .out_valid (m_tvalid),
        .out_data  (res),
        .out_ready (m_tready)
    );

    assign m_tdata = {2'b00, res.right, res.left};
    assign m_tuser = res.mode;

endmodule

`default_nettype wire

// ===== rtl/core/lfs_checker.sv =====
// ============================================================================
// lfs_checker: port-level checks of the line follow steering core
// Watches the result channel for power ranges, mode rules and stall behavior.
// ============================================================================
`default_nettype none

module lfs_checker
    import lfs_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:0] <= 7'(POWER_MAX) && m_tdata[13:7] <= 7'(POWER_MAX)))
        else $error("motor power above full scale");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == MODE_BLACK) |-> (m_tdata[6:0] == m_tdata[13:7]))
        else $error("straight drive with unequal powers");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == MODE_WHITE) |-> (m_tdata[6:0] == 7'd0))
        else $error("spin with left motor driven");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result transaction changed");

endmodule

bind line_follow_steering_core lfs_checker u_lfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
